FILE: rtl/word_match_count_top_defines.svh
// ----------------------------------------------------------------------------
// Word match counter: assertion macros
// Shared property wrappers, sampled on clk_i and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef WORD_MATCH_COUNT_TOP_DEFINES_SVH
`define WORD_MATCH_COUNT_TOP_DEFINES_SVH

// same-cycle implication
`define WMC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/wmc_pkg.sv
// ----------------------------------------------------------------------------
// Word match counter package
// Item types, command codes, controller/datapath buses and size constants.
// ----------------------------------------------------------------------------
package wmc_pkg;

  localparam int FRAME_MAX_DEF = 128;
  localparam int WORD_MAX_DEF  = 16;
  localparam int WS_W          = 5;
  localparam int OUT_W         = 14;
  localparam int SYM_W         = 8;

  localparam logic [WS_W-1:0]  WORD_SIZE_RST = WS_W'(6);
  localparam logic [OUT_W-1:0] OUT_MAX       = {OUT_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_REF     = 2'd0,
    CMD_OTHER   = 2'd1,
    CMD_COMPUTE = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [1:0]       command;
    logic [SYM_W-1:0] symbol;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] match_count;
    logic [OUT_W-1:0] denominator;
    logic             no_words;
  } out_item_t;

  typedef logic [WS_W-1:0] cfg_item_t;

  // controller -> datapath
  typedef struct packed {
    logic wr_ref;
    logic wr_other;
    logic setup;
    logic step;
    logic finish;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic skip;
    logic last;
  } dp_status_t;

endpackage

FILE: rtl/wmc_stream_if.sv
// ----------------------------------------------------------------------------
// Word match counter stream interface
// Valid/ready channel carrying one item of type T.
// ----------------------------------------------------------------------------
interface wmc_stream_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

FILE: rtl/word_match_count_top.sv
// ----------------------------------------------------------------------------
// Word match counter top level
// Frame loading, occurrence count of reference words and result output.
// ----------------------------------------------------------------------------
// Append commands each load one byte into the reference or
// the other frame (bytes beyond FRAME_MAX are dropped). A compute command
// holds input ready low through a setup step, a read and a compare step per
// byte compare, and a step to load the result; B is the number of byte compares:
// every reference word start is tried at every start in the other frame and a
// word stops at its first differing byte, so B is at most
// P * (L - W + 1) * W for P word positions, other length L and word size W.
// A compare has a read step and a compare step: each frame memory has one read port
// with registered read data. The result waits in an output register; a
// compute that finishes while the previous result is still unread waits for
// it to be taken. Both frames are empty again once the result is loaded.
module word_match_count_top #(
  parameter int FRAME_MAX = wmc_pkg::FRAME_MAX_DEF,
  parameter int WORD_MAX  = wmc_pkg::WORD_MAX_DEF
) (
  input logic          clk_i,
  input logic          rst_ni,
  wmc_stream_if.sink   in_i,
  wmc_stream_if.source res_o,
  wmc_stream_if.sink   cfg_i
);

  wmc_pkg::ctrl_cmd_t  cmd;
  wmc_pkg::dp_status_t status;
  wmc_pkg::in_item_t   in_item;
  wmc_pkg::out_item_t  res_item;

  assign in_item     = in_i.data;
  assign res_o.data  = res_item;
  assign cfg_i.ready = 1'b1;

  wmc_controller u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_command_i (in_item.command),
    .in_ready_o   (in_i.ready),
    .res_valid_o  (res_o.valid),
    .res_ready_i  (res_o.ready),
    .cmd_o        (cmd),
    .status_i     (status)
  );

  wmc_datapath #(
    .FRAME_MAX (FRAME_MAX),
    .WORD_MAX  (WORD_MAX)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .symbol_i    (in_item.symbol),
    .cfg_valid_i (cfg_i.valid),
    .cfg_data_i  (cfg_i.data),
    .res_data_o  (res_item)
  );

endmodule

FILE: rtl/wmc_datapath.sv
// ----------------------------------------------------------------------------
// Word match counter datapath
// Frame memories, lengths, word size register, scan counters and result.
// ----------------------------------------------------------------------------
module wmc_datapath #(
  parameter int FRAME_MAX = wmc_pkg::FRAME_MAX_DEF,
  parameter int WORD_MAX  = wmc_pkg::WORD_MAX_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  wmc_pkg::ctrl_cmd_t          cmd_i,
  output wmc_pkg::dp_status_t         status_o,
  input  logic [wmc_pkg::SYM_W-1:0]   symbol_i,
  input  logic                        cfg_valid_i,
  input  wmc_pkg::cfg_item_t          cfg_data_i,
  output wmc_pkg::out_item_t          res_data_o
);

  localparam int AW = $clog2(FRAME_MAX);
  localparam int LW = $clog2(FRAME_MAX + 1);
  localparam int EW = $clog2(WORD_MAX + 1);
  localparam int CW = (EW > wmc_pkg::WS_W) ? EW : wmc_pkg::WS_W;
  localparam int XW = ((LW > EW) ? LW : EW) + 1;
  localparam int PW = (2 * LW > wmc_pkg::OUT_W) ? 2 * LW : wmc_pkg::OUT_W;

  logic [wmc_pkg::SYM_W-1:0] ref_mem [FRAME_MAX];
  logic [wmc_pkg::SYM_W-1:0] oth_mem [FRAME_MAX];
  logic [wmc_pkg::SYM_W-1:0] ref_rd_q, oth_rd_q;

  logic [LW-1:0]             ref_len_q, oth_len_q;
  logic [wmc_pkg::WS_W-1:0]  word_size_q;

  logic [EW-1:0]             w_q;
  logic [LW-1:0]             positions_q;
  logic                      no_words_q;
  logic [AW-1:0]             rpos_q, opos_q;
  logic [EW-1:0]             k_q;
  logic [wmc_pkg::OUT_W-1:0] count_q;
  wmc_pkg::out_item_t        res_q;

  logic [CW-1:0]             ws_c;
  logic [EW-1:0]             eff_c;
  logic                      no_words_c;
  logic [XW-1:0]             ref_sum_c, oth_sum_c;
  logic [AW-1:0]             ref_addr_c, oth_addr_c;
  logic                      eq_c, k_last_c, word_done_c, opos_last_c, rpos_last_c;
  logic [PW-1:0]             prod_c;
  logic [wmc_pkg::OUT_W-1:0] denom_c;

  // word size clamped to 1..WORD_MAX
  always_comb begin
    ws_c = CW'(word_size_q);
    if (ws_c == '0) begin
      eff_c = EW'(1);
    end else if (ws_c > CW'(WORD_MAX)) begin
      eff_c = EW'(WORD_MAX);
    end else begin
      eff_c = EW'(ws_c);
    end
  end

  assign no_words_c = XW'(ref_len_q) <= XW'(eff_c);

  assign ref_sum_c  = XW'(rpos_q) + XW'(k_q);
  assign oth_sum_c  = XW'(opos_q) + XW'(k_q);
  assign ref_addr_c = ref_sum_c[AW-1:0];
  assign oth_addr_c = oth_sum_c[AW-1:0];

  assign eq_c        = ref_rd_q == oth_rd_q;
  assign k_last_c    = k_q == (w_q - EW'(1));
  assign word_done_c = !eq_c || k_last_c;
  assign opos_last_c = XW'(opos_q) == (XW'(oth_len_q) - XW'(w_q));
  assign rpos_last_c = XW'(rpos_q) == (XW'(positions_q) - XW'(1));

  assign status_o.skip = no_words_c || (XW'(oth_len_q) < XW'(eff_c));
  assign status_o.last = word_done_c && opos_last_c && rpos_last_c;

  assign prod_c  = PW'(positions_q) * PW'(positions_q);
  assign denom_c = (prod_c > PW'(wmc_pkg::OUT_MAX)) ? wmc_pkg::OUT_MAX
                                                     : wmc_pkg::OUT_W'(prod_c);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_ref && (ref_len_q < LW'(FRAME_MAX))) begin
      ref_mem[ref_len_q[AW-1:0]] <= symbol_i;
    end
    ref_rd_q <= ref_mem[ref_addr_c];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_other && (oth_len_q < LW'(FRAME_MAX))) begin
      oth_mem[oth_len_q[AW-1:0]] <= symbol_i;
    end
    oth_rd_q <= oth_mem[oth_addr_c];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_len_q   <= '0;
      oth_len_q   <= '0;
      word_size_q <= wmc_pkg::WORD_SIZE_RST;
    end else begin
      if (cfg_valid_i) begin
        word_size_q <= cfg_data_i;
      end
      if (cmd_i.finish) begin
        ref_len_q <= '0;
        oth_len_q <= '0;
      end else begin
        if (cmd_i.wr_ref && (ref_len_q < LW'(FRAME_MAX))) begin
          ref_len_q <= ref_len_q + LW'(1);
        end
        if (cmd_i.wr_other && (oth_len_q < LW'(FRAME_MAX))) begin
          oth_len_q <= oth_len_q + LW'(1);
        end
      end
    end
  end

  // scan: reference start, other start, byte within word; early out on mismatch
  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      w_q         <= eff_c;
      no_words_q  <= no_words_c;
      positions_q <= no_words_c ? '0 : LW'(XW'(ref_len_q) - XW'(eff_c));
      rpos_q      <= '0;
      opos_q      <= '0;
      k_q         <= '0;
      count_q     <= '0;
    end else if (cmd_i.step) begin
      if (!word_done_c) begin
        k_q <= k_q + EW'(1);
      end else begin
        k_q <= '0;
        if (eq_c && (count_q != wmc_pkg::OUT_MAX)) begin
          count_q <= count_q + wmc_pkg::OUT_W'(1);
        end
        if (opos_last_c) begin
          opos_q <= '0;
          if (!rpos_last_c) begin
            rpos_q <= rpos_q + AW'(1);
          end
        end else begin
          opos_q <= opos_q + AW'(1);
        end
      end
    end
    if (cmd_i.finish) begin
      res_q.match_count <= count_q;
      res_q.denominator <= denom_c;
      res_q.no_words    <= no_words_q;
    end
  end

  assign res_data_o = res_q;

endmodule

FILE: rtl/wmc_controller.sv
// ----------------------------------------------------------------------------
// Word match counter controller
// Input handshake, scan sequencing and result valid flag.
// ----------------------------------------------------------------------------
module wmc_controller (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          in_command_i,
  output logic                in_ready_o,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output wmc_pkg::ctrl_cmd_t  cmd_o,
  input  wmc_pkg::dp_status_t status_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_READ,
    ST_CMP,
    ST_FINISH
  } state_e;

  state_e state_q;
  logic   res_valid_q;
  logic   accept;

  assign in_ready_o = state_q == ST_IDLE;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o.wr_ref   = accept && (in_command_i == wmc_pkg::CMD_REF);
    cmd_o.wr_other = accept && (in_command_i == wmc_pkg::CMD_OTHER);
    cmd_o.setup    = state_q == ST_SETUP;
    cmd_o.step     = state_q == ST_CMP;
    cmd_o.finish   = (state_q == ST_FINISH) && (!res_valid_q || res_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept && (in_command_i == wmc_pkg::CMD_COMPUTE)) begin
            state_q <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          state_q <= status_i.skip ? ST_FINISH : ST_READ;
        end
        // read data registered in the memories, compared in the cycle after
        ST_READ: begin
          state_q <= ST_CMP;
        end
        ST_CMP: begin
          state_q <= status_i.last ? ST_FINISH : ST_READ;
        end
        ST_FINISH: begin
          if (cmd_o.finish) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase

      if (cmd_o.finish) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  assign res_valid_o = res_valid_q;

endmodule

FILE: rtl/wmc_checker.sv
// ----------------------------------------------------------------------------
// Word match counter port checker
// Port-level properties of the top level, attached by bind.
// ----------------------------------------------------------------------------
`include "word_match_count_top_defines.svh"

module wmc_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic [1:0]                in_command_i,
  input logic                      res_valid_i,
  input logic                      res_ready_i,
  input logic [wmc_pkg::OUT_W-1:0] res_match_count_i,
  input logic [wmc_pkg::OUT_W-1:0] res_denominator_i,
  input logic                      res_no_words_i
);

  `WMC_ASSERT_NEXT(a_res_hold, res_valid_i && !res_ready_i,
    res_valid_i && $stable(res_match_count_i) && $stable(res_denominator_i)
    && $stable(res_no_words_i), "result changed while stalled")

  `WMC_ASSERT_NOW(a_no_words_zero, res_valid_i && res_no_words_i,
    (res_match_count_i == '0) && (res_denominator_i == '0),
    "no_words result with nonzero fields")

  `WMC_ASSERT_NOW(a_count_needs_denom, res_valid_i && (res_match_count_i != '0),
    (res_denominator_i != '0) && !res_no_words_i,
    "matches reported without word positions")

  `WMC_ASSERT_NEXT(a_compute_busy,
    in_valid_i && in_ready_i && (in_command_i == wmc_pkg::CMD_COMPUTE),
    !in_ready_i, "input still ready right after compute")

endmodule

bind word_match_count_top wmc_checker u_wmc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .in_command_i      (in_i.data.command),
  .res_valid_i       (res_o.valid),
  .res_ready_i       (res_o.ready),
  .res_match_count_i (res_o.data.match_count),
  .res_denominator_i (res_o.data.denominator),
  .res_no_words_i    (res_o.data.no_words)
);
